FILE: rtl/core/ppam_pkg.sv
// types, codes and helpers shared by the public/private address map
`default_nettype none

package ppam_pkg;

    localparam int ADDR_W = 64;
    localparam int PORT_W = 16;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_PUB2PRIV = 2'd1;
    localparam logic [1:0] OP_PRIV2PUB = 2'd2;

    localparam logic FAM_IPV4 = 1'b0;

    typedef enum logic [1:0] {
        ST_TRANSLATED = 2'd0,
        ST_PASSED     = 2'd1,
        ST_ADDED      = 2'd2,
        ST_FULL       = 2'd3
    } ppam_status_t;

    typedef struct packed {
        logic [1:0]        op;
        logic              family;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [PORT_W-1:0] port_number;
        logic              pair_family;
        logic [ADDR_W-1:0] pair_addr_high;
        logic [ADDR_W-1:0] pair_addr_low;
    } ppam_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              out_family;
        logic [ADDR_W-1:0] out_addr_high;
        logic [ADDR_W-1:0] out_addr_low;
        logic [PORT_W-1:0] out_port;
    } ppam_rsp_t;

    typedef struct packed {
        logic              pub_family;
        logic [ADDR_W-1:0] pub_high;
        logic [ADDR_W-1:0] pub_low;
        logic              priv_family;
        logic [ADDR_W-1:0] priv_high;
        logic [ADDR_W-1:0] priv_low;
    } ppam_entry_t;

    typedef struct packed {
        logic              done;
        logic [1:0]        op;
        logic              family;
        logic [ADDR_W-1:0] addr_high;
        logic [ADDR_W-1:0] addr_low;
        logic [PORT_W-1:0] port;
        ppam_status_t      status;
        logic              res_family;
        logic [ADDR_W-1:0] res_high;
        logic [ADDR_W-1:0] res_low;
    } ppam_token_t;

    function automatic logic addr_match(
        input logic              fam_a,
        input logic [ADDR_W-1:0] high_a,
        input logic [ADDR_W-1:0] low_a,
        input logic              fam_b,
        input logic [ADDR_W-1:0] high_b,
        input logic [ADDR_W-1:0] low_b
    );
        logic same;
        if (fam_a != fam_b)
            same = 1'b0;
        else if (fam_a == FAM_IPV4)
            same = (low_a[31:0] == low_b[31:0]);
        else
            same = (high_a == high_b) && (low_a == low_b);
        return same;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ppam_req_if.sv
// request channel: valid/ready with one address map request per beat
`default_nettype none

interface ppam_req_if
    import ppam_pkg::*;
;
    logic      valid;
    logic      ready;
    ppam_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ppam_rsp_if.sv
// response channel: valid/ready with one address map result per beat
`default_nettype none

interface ppam_rsp_if
    import ppam_pkg::*;
;
    logic      valid;
    logic      ready;
    ppam_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/public_private_address_map.sv
// top level of the public/private address map: request intake, cell row, result register
//
// Static one-to-one address table of TABLE_ENTRIES public/private pairs held in a row
// of cells, one pair per cell. An add stores the pair in the next free cell at once, or
// answers table full; a lookup walks the row one cell per cycle unless a full output
// register stalls it, and the first cell that matches on family and address replaces
// the address, keeping the query's port. Every request gives one result beat once it
// has passed every cell of the row. One request is in the row at a time, so a new
// request is taken only after the last one has left the row; a finished result may
// wait in the output register while the next request is already walking.
`default_nettype none

module public_private_address_map
    import ppam_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ppam_req_if.sink   req,
    ppam_rsp_if.source rsp
);

    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_ENTRIES);

    logic [COUNT_W-1:0] count_reg;
    logic               in_flight_reg;
    logic               rsp_valid_reg;
    ppam_rsp_t          rsp_data_reg;

    logic               accept;
    logic               is_add;
    logic               is_lookup;
    logic               table_full;
    logic               wr_en;
    logic               advance;
    logic               leave;
    ppam_entry_t        wr_entry;
    ppam_token_t        token_first;
    logic               busy_chain  [TABLE_ENTRIES+1];
    ppam_token_t        token_chain [TABLE_ENTRIES+1];

    assign accept     = req.valid && req.ready;
    assign is_add     = (req.payload.op == OP_ADD);
    assign is_lookup  = (req.payload.op == OP_PUB2PRIV) || (req.payload.op == OP_PRIV2PUB);
    assign table_full = (count_reg >= FULL_COUNT);
    assign wr_en      = accept && is_add && !table_full;

    assign leave   = busy_chain[TABLE_ENTRIES] && (!rsp_valid_reg || rsp.ready);
    assign advance = !busy_chain[TABLE_ENTRIES] || leave;

    assign req.ready = !in_flight_reg;

    // ipv4 sides are stored with the upper bits cleared
    always_comb
    begin
        wr_entry.pub_family  = req.payload.family;
        wr_entry.pub_high    = (req.payload.family == FAM_IPV4) ? '0 : req.payload.addr_high;
        wr_entry.pub_low     = (req.payload.family == FAM_IPV4)
                             ? {32'd0, req.payload.addr_low[31:0]} : req.payload.addr_low;
        wr_entry.priv_family = req.payload.pair_family;
        wr_entry.priv_high   = (req.payload.pair_family == FAM_IPV4)
                             ? '0 : req.payload.pair_addr_high;
        wr_entry.priv_low    = (req.payload.pair_family == FAM_IPV4)
                             ? {32'd0, req.payload.pair_addr_low[31:0]}
                             : req.payload.pair_addr_low;
    end

    always_comb
    begin
        token_first.done       = !is_lookup;
        token_first.op         = req.payload.op;
        token_first.family     = req.payload.family;
        token_first.addr_high  = req.payload.addr_high;
        token_first.addr_low   = req.payload.addr_low;
        token_first.port       = is_add ? '0 : req.payload.port_number;
        token_first.res_family = is_add ? 1'b0 : req.payload.family;
        token_first.res_high   = is_add ? '0 : req.payload.addr_high;
        token_first.res_low    = is_add ? '0 : req.payload.addr_low;
        if (is_add)
            token_first.status = table_full ? ST_FULL : ST_ADDED;
        else
            token_first.status = ST_PASSED;
    end

    assign busy_chain[0]  = accept;
    assign token_chain[0] = token_first;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        ppam_cell #(
            .INDEX   (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .entry_count (count_reg),
            .wr_en       (wr_en),
            .wr_entry    (wr_entry),
            .busy_in     (busy_chain[i]),
            .token_in    (token_chain[i]),
            .busy_out    (busy_chain[i+1]),
            .token_out   (token_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            in_flight_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                count_reg <= count_reg + COUNT_W'(1);
            if (accept)
                in_flight_reg <= 1'b1;
            else if (leave)
                in_flight_reg <= 1'b0;
            if (leave)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (leave)
        begin
            rsp_data_reg.status        <= token_chain[TABLE_ENTRIES].status;
            rsp_data_reg.out_family    <= token_chain[TABLE_ENTRIES].res_family;
            rsp_data_reg.out_addr_high <= token_chain[TABLE_ENTRIES].res_high;
            rsp_data_reg.out_addr_low  <= token_chain[TABLE_ENTRIES].res_low;
            rsp_data_reg.out_port      <= token_chain[TABLE_ENTRIES].port;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ppam_cell.sv
// one table entry with its compare stage in the lookup chain
`default_nettype none

module ppam_cell
    import ppam_pkg::*;
#(
    parameter int INDEX   = 0,
    parameter int COUNT_W = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic [COUNT_W-1:0] entry_count,
    input  wire logic               wr_en,
    input  wire ppam_entry_t        wr_entry,
    input  wire logic               busy_in,
    input  wire ppam_token_t        token_in,
    output logic                    busy_out,
    output ppam_token_t             token_out
);

    localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(INDEX);

    ppam_entry_t entry_reg;
    logic        busy_reg;
    ppam_token_t token_reg;
    ppam_token_t token_next;
    logic        hit;

    always_comb
    begin
        token_next = token_in;
        if (token_in.op == OP_PUB2PRIV)
            hit = addr_match(token_in.family, token_in.addr_high, token_in.addr_low,
                             entry_reg.pub_family, entry_reg.pub_high, entry_reg.pub_low);
        else
            hit = addr_match(token_in.family, token_in.addr_high, token_in.addr_low,
                             entry_reg.priv_family, entry_reg.priv_high,
                             entry_reg.priv_low);
        hit = hit && !token_in.done && (MY_INDEX < entry_count);
        if (hit)
        begin
            token_next.done   = 1'b1;
            token_next.status = ST_TRANSLATED;
            if (token_in.op == OP_PUB2PRIV)
            begin
                token_next.res_family = entry_reg.priv_family;
                token_next.res_high   = entry_reg.priv_high;
                token_next.res_low    = entry_reg.priv_low;
            end
            else
            begin
                token_next.res_family = entry_reg.pub_family;
                token_next.res_high   = entry_reg.pub_high;
                token_next.res_low    = entry_reg.pub_low;
            end
        end
    end

    // entry storage, written once at its turn in the fill order
    always_ff @(posedge clk)
    begin
        if (wr_en && (entry_count == MY_INDEX))
            entry_reg <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (advance)
            busy_reg <= busy_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            token_reg <= token_next;
    end

    assign busy_out  = busy_reg;
    assign token_out = token_reg;

endmodule

`default_nettype wire

FILE: test/ppam_map_checker.sv
`timescale 1ns / 100ps
// checker for the address map: mirrors the pair table, predicts every result beat and compares
module ppam_map_checker
    import ppam_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  ppam_req_t req_beat,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  ppam_rsp_t rsp_beat,
    output int        errors,
    output int        pending
);

    ppam_entry_t nat_table [TABLE_ENTRIES];
    int          used_entries;
    ppam_rsp_t   due_results [$];
    ppam_rsp_t   predicted;
    ppam_rsp_t   oldest;

    function automatic logic same_address(
        input logic              fam_a,
        input logic [ADDR_W-1:0] hi_a,
        input logic [ADDR_W-1:0] lo_a,
        input logic              fam_b,
        input logic [ADDR_W-1:0] hi_b,
        input logic [ADDR_W-1:0] lo_b
    );
        if (fam_a != fam_b)
            return 1'b0;
        if (fam_a == FAM_IPV4)
            return lo_a[31:0] == lo_b[31:0];
        return {hi_a, lo_a} == {hi_b, lo_b};
    endfunction

    function automatic logic [ADDR_W-1:0] kept_high(input logic fam, input logic [ADDR_W-1:0] hi);
        return (fam == FAM_IPV4) ? '0 : hi;
    endfunction

    function automatic logic [ADDR_W-1:0] kept_low(input logic fam, input logic [ADDR_W-1:0] lo);
        return (fam == FAM_IPV4) ? {32'd0, lo[31:0]} : lo;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic translate_request(input ppam_req_t r, output ppam_rsp_t res);
        ppam_entry_t e;
        logic        found;
        found = 1'b0;
        res = '0;
        if (r.op == OP_ADD)
        begin
            if (used_entries >= TABLE_ENTRIES)
                res.status = ST_FULL;
            else
            begin
                e.pub_family  = r.family;
                e.pub_high    = kept_high(r.family, r.addr_high);
                e.pub_low     = kept_low(r.family, r.addr_low);
                e.priv_family = r.pair_family;
                e.priv_high   = kept_high(r.pair_family, r.pair_addr_high);
                e.priv_low    = kept_low(r.pair_family, r.pair_addr_low);
                nat_table[used_entries] = e;
                used_entries++;
                res.status = ST_ADDED;
            end
        end
        else
        begin
            if (r.op == OP_PUB2PRIV || r.op == OP_PRIV2PUB)
            begin
                for (int i = 0; i < used_entries && !found; i++)
                begin
                    e = nat_table[i];
                    if (r.op == OP_PUB2PRIV &&
                        same_address(r.family, r.addr_high, r.addr_low,
                                     e.pub_family, e.pub_high, e.pub_low))
                    begin
                        found = 1'b1;
                        res.out_family    = e.priv_family;
                        res.out_addr_high = e.priv_high;
                        res.out_addr_low  = e.priv_low;
                    end
                    else if (r.op == OP_PRIV2PUB &&
                             same_address(r.family, r.addr_high, r.addr_low,
                                          e.priv_family, e.priv_high, e.priv_low))
                    begin
                        found = 1'b1;
                        res.out_family    = e.pub_family;
                        res.out_addr_high = e.pub_high;
                        res.out_addr_low  = e.pub_low;
                    end
                end
            end
            if (found)
                res.status = ST_TRANSLATED;
            else
            begin
                res.status        = ST_PASSED;
                res.out_family    = r.family;
                res.out_addr_high = r.addr_high;
                res.out_addr_low  = r.addr_low;
            end
            res.out_port = r.port_number;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors = 0;
            used_entries = 0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                translate_request(req_beat, predicted);
                due_results.push_back(predicted);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (due_results.size() == 0)
                    report_error($sformatf("result beat with nothing due, status %0d",
                                           rsp_beat.status));
                else
                begin
                    oldest = due_results.pop_front();
                    if (rsp_beat.status !== oldest.status)
                        report_error($sformatf("status got %0d, expected %0d",
                                               rsp_beat.status, oldest.status));
                    if (rsp_beat.out_family !== oldest.out_family)
                        report_error($sformatf("family got %0d, expected %0d",
                                               rsp_beat.out_family, oldest.out_family));
                    if (rsp_beat.out_addr_high !== oldest.out_addr_high)
                        report_error($sformatf("addr high got %h, expected %h",
                                               rsp_beat.out_addr_high, oldest.out_addr_high));
                    if (rsp_beat.out_addr_low !== oldest.out_addr_low)
                        report_error($sformatf("addr low got %h, expected %h",
                                               rsp_beat.out_addr_low, oldest.out_addr_low));
                    if (rsp_beat.out_port !== oldest.out_port)
                        report_error($sformatf("port got %h, expected %h",
                                               rsp_beat.out_port, oldest.out_port));
                end
            end
            pending <= due_results.size();
        end
    end

endmodule

FILE: test/tb_public_private_address_map.sv
`timescale 1ns / 100ps
// testbench top for the address map: clock, reset, request beats, result back-pressure and verdict
module tb_public_private_address_map;
    import ppam_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int RANDOM_BEATS  = 780;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic       FAM_IPV6  = 1'b1;

    localparam logic [ADDR_W-1:0] ONES = '1;
    localparam logic [ADDR_W-1:0] ZERO = '0;

    typedef struct packed {
        logic              fam;
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
    } ip_side_t;

    logic        clk    = 1'b0;
    logic        rst_n  = 1'b0;
    logic        steady = 1'b0;
    int          cycles = 0;
    int          errors;
    int          pending;
    ppam_entry_t pairs_sent [$];

    ppam_req_if req_ch ();
    ppam_rsp_if rsp_ch ();

    public_private_address_map #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ppam_map_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) watch (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .req_beat  (req_ch.payload),
        .rsp_valid (rsp_ch.valid),
        .rsp_ready (rsp_ch.ready),
        .rsp_beat  (rsp_ch.payload),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_ch.ready <= steady || ($urandom_range(99) >= 37);

    function automatic logic [ADDR_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic ppam_req_t make_req(
        input logic [1:0]        op,
        input logic              fam,
        input logic [ADDR_W-1:0] hi,
        input logic [ADDR_W-1:0] lo,
        input logic [PORT_W-1:0] port,
        input logic              pfam,
        input logic [ADDR_W-1:0] phi,
        input logic [ADDR_W-1:0] plo
    );
        ppam_req_t r;
        r.op             = op;
        r.family         = fam;
        r.addr_high      = hi;
        r.addr_low       = lo;
        r.port_number    = port;
        r.pair_family    = pfam;
        r.pair_addr_high = phi;
        r.pair_addr_low  = plo;
        return r;
    endfunction

    // a quarter of the addresses come from a tiny pool so that repeats happen
    function automatic ip_side_t random_side();
        ip_side_t s;
        s.fam = 1'($urandom_range(1));
        if ($urandom_range(99) < 25)
        begin
            s.hi = (s.fam == FAM_IPV4) ? rand_word() : ZERO;
            s.lo = {(s.fam == FAM_IPV4) ? $urandom : 32'd0, $urandom_range(3)};
        end
        else
        begin
            s.hi = rand_word();
            s.lo = rand_word();
        end
        return s;
    endfunction

    function automatic ppam_req_t random_add();
        ip_side_t    pub;
        ip_side_t    priv;
        ppam_entry_t e;
        int          u;
        pub  = random_side();
        priv = random_side();
        if (pairs_sent.size() > 0)
        begin
            u = $urandom_range(99);
            e = pairs_sent[$urandom_range(pairs_sent.size() - 1)];
            if (u < 25)
                pub = {e.pub_family, e.pub_high, e.pub_low};
            if (u >= 15 && u < 25)
                priv = {e.priv_family, e.priv_high, e.priv_low};
        end
        return make_req(OP_ADD, pub.fam, pub.hi, pub.lo, PORT_W'($urandom),
                        priv.fam, priv.hi, priv.lo);
    endfunction

    // mostly queries of a side already in the table, some crossed, some one bit off
    function automatic ppam_req_t random_lookup();
        logic [1:0]  op;
        ppam_entry_t e;
        ip_side_t    s;
        ip_side_t    junk;
        logic        use_pub;
        op   = $urandom_range(1) ? OP_PUB2PRIV : OP_PRIV2PUB;
        s    = random_side();
        junk = random_side();
        if (pairs_sent.size() > 0 && $urandom_range(99) < 75)
        begin
            e = pairs_sent[$urandom_range(pairs_sent.size() - 1)];
            use_pub = (op == OP_PUB2PRIV) ^ ($urandom_range(99) < 10);
            s = use_pub ? {e.pub_family, e.pub_high, e.pub_low}
                        : {e.priv_family, e.priv_high, e.priv_low};
            if (s.fam == FAM_IPV4 && $urandom_range(1))
            begin
                s.hi        = rand_word();
                s.lo[63:32] = $urandom;
            end
            if ($urandom_range(99) < 10)
                s.lo = s.lo ^ (ADDR_W'(1) << $urandom_range(63));
        end
        return make_req(op, s.fam, s.hi, s.lo, PORT_W'($urandom), junk.fam, junk.hi, junk.lo);
    endfunction

    task automatic send_beat(input ppam_req_t r);
        ppam_entry_t e;
        req_ch.payload <= r;
        req_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (r.op == OP_ADD && pairs_sent.size() < TABLE_ENTRIES)
        begin
            e.pub_family  = r.family;
            e.pub_high    = r.addr_high;
            e.pub_low     = r.addr_low;
            e.priv_family = r.pair_family;
            e.priv_high   = r.pair_addr_high;
            e.priv_low    = r.pair_addr_low;
            pairs_sent.push_back(e);
        end
        if (!steady)
        begin
            while ($urandom_range(99) < 37)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        ppam_req_t r;
        int        u;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: both directions pass through
        send_beat(make_req(OP_PUB2PRIV, FAM_IPV4, ZERO, ZERO, 16'h0000, FAM_IPV4, ZERO, ZERO));
        send_beat(make_req(OP_PRIV2PUB, FAM_IPV6, ONES, ONES, 16'hffff, FAM_IPV6, ONES, ONES));
        // adds, some ipv4 sides carry junk above bit 31
        send_beat(make_req(OP_ADD, FAM_IPV6, ONES, ONES, 16'hffff, FAM_IPV4, ONES, ONES));
        send_beat(make_req(OP_ADD, FAM_IPV4, rand_word(), 64'hdead_beef_0a00_0001, 16'h1234,
                           FAM_IPV6, ZERO, ZERO));
        send_beat(make_req(OP_ADD, FAM_IPV4, ZERO, 64'h0000_0000_c0a8_0001, 16'h0000,
                           FAM_IPV6, ONES, ZERO));
        // hits both ways, ipv4 queries with junk upper bits
        send_beat(make_req(OP_PUB2PRIV, FAM_IPV6, ONES, ONES, 16'h1234, FAM_IPV4, ZERO, ZERO));
        send_beat(make_req(OP_PRIV2PUB, FAM_IPV4, rand_word(), 64'h1234_5678_ffff_ffff,
                           16'hffff, FAM_IPV6, ONES, ONES));
        send_beat(make_req(OP_PUB2PRIV, FAM_IPV4, ONES, 64'hffff_ffff_0a00_0001, 16'h0001,
                           FAM_IPV4, ZERO, ZERO));
        send_beat(make_req(OP_PRIV2PUB, FAM_IPV6, ZERO, ZERO, 16'h8000, FAM_IPV4, ONES, ONES));
        send_beat(make_req(OP_PRIV2PUB, FAM_IPV6, ONES, ZERO, 16'h7fff, FAM_IPV6, ZERO, ZERO));
        // family differs, same low bits
        send_beat(make_req(OP_PUB2PRIV, FAM_IPV6, ZERO, 64'h0000_0000_0a00_0001, 16'h0050,
                           FAM_IPV4, ZERO, ZERO));
        send_beat(make_req(OP_PRIV2PUB, FAM_IPV6, ZERO, 64'h0000_0000_ffff_ffff, 16'h0050,
                           FAM_IPV4, ZERO, ZERO));
        // unused op code never translates
        send_beat(make_req(OP_UNUSED, FAM_IPV6, ONES, ONES, 16'hffff, FAM_IPV6, ONES, ONES));
        send_beat(make_req(OP_UNUSED, FAM_IPV4, ZERO, 64'h0000_0000_0a00_0001, 16'h0000,
                           FAM_IPV4, ZERO, ZERO));
        // duplicates: earliest entry wins
        send_beat(make_req(OP_ADD, FAM_IPV4, ZERO, 64'h0000_0000_0a00_0001, 16'h0000,
                           FAM_IPV6, 64'h1111_1111_1111_1111, 64'h2222_2222_2222_2222));
        send_beat(make_req(OP_ADD, FAM_IPV6, ONES, ONES, 16'h0000, FAM_IPV4, ZERO, ONES));
        send_beat(make_req(OP_PUB2PRIV, FAM_IPV4, ZERO, 64'h0000_0000_0a00_0001, 16'habcd,
                           FAM_IPV4, ZERO, ZERO));
        send_beat(make_req(OP_PUB2PRIV, FAM_IPV6, ONES, ONES, 16'h4321, FAM_IPV4, ZERO, ZERO));
        send_beat(make_req(OP_PRIV2PUB, FAM_IPV6, 64'h1111_1111_1111_1111,
                           64'h2222_2222_2222_2222, 16'h0443, FAM_IPV6, ONES, ONES));
        send_beat(make_req(OP_PUB2PRIV, FAM_IPV4, ZERO, ZERO, 16'h0000, FAM_IPV4, ZERO, ZERO));

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            steady <= (n >= 300 && n < 420);
            if (n == 500)
            begin
                req_ch.valid <= 1'b0;
                drain_results();
            end
            u = $urandom_range(99);
            if (u < 12)
                r = random_add();
            else
            begin
                r = random_lookup();
                if (u < 15)
                    r.op = OP_UNUSED;
            end
            send_beat(r);
        end

        req_ch.valid <= 1'b0;
        drain_results();
        repeat (2 * TABLE_ENTRIES + 8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: public_private_address_map.f
rtl/core/ppam_pkg.sv
rtl/core/ppam_req_if.sv
rtl/core/ppam_rsp_if.sv
rtl/core/ppam_cell.sv
rtl/core/public_private_address_map.sv
test/ppam_map_checker.sv
test/tb_public_private_address_map.sv
